@@ hdl/yuyv_to_rgb_converter_unit_macros.svh @@
// Assertion macros used by the checker of the converter unit.
`ifndef YUYV_TO_RGB_CONVERTER_UNIT_MACROS_SVH
`define YUYV_TO_RGB_CONVERTER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define Y2R_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("y2r assertion failed");

// Next-cycle implication, disabled while reset is active.
`define Y2R_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("y2r assertion failed");

// Implication after a fixed number of cycles, disabled while reset is active.
`define Y2R_ASSERT_DELAY(label, clk, rst_n, ante, dly, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##dly (cons)) \
    else $error("y2r assertion failed");

`endif

@@ hdl/y2r_pkg.sv @@
package y2r_pkg;

  localparam int FRAC_BITS = 16;
  localparam int PROD_W    = 25;
  localparam int ACC_W     = 27;
  localparam int LATENCY   = 3;

  localparam logic signed [PROD_W-1:0] K_RED_V   = 25'sd91881;
  localparam logic signed [PROD_W-1:0] K_GREEN_U = 25'sd22544;
  localparam logic signed [PROD_W-1:0] K_GREEN_V = 25'sd46793;
  localparam logic signed [PROD_W-1:0] K_BLUE_U  = 25'sd116130;

  localparam logic MODE_CONVERT = 1'b0;
  localparam logic MODE_UNPACK  = 1'b1;

  typedef struct packed {
    logic [7:0] first_luma;
    logic [7:0] blue_chroma;
    logic [7:0] second_luma;
    logic [7:0] red_chroma;
  } in_t;

  typedef struct packed {
    logic [7:0] left_chan_a;
    logic [7:0] left_chan_b;
    logic [7:0] left_chan_c;
    logic [7:0] right_chan_a;
    logic [7:0] right_chan_b;
    logic [7:0] right_chan_c;
  } out_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] blue_term;
    logic signed [PROD_W-1:0] green_term;
    logic signed [PROD_W-1:0] red_term;
  } prod_t;

endpackage

@@ hdl/yuyv_to_rgb_converter_unit.sv @@
// YUYV macropixel to two pixels, blue/green/red (full-range BT.601) or
// unpacked Y/U/V.
// Input: drive in_data with one macropixel and raise start; the transaction
// is taken at a rising edge with start high and busy low. busy is high only
// while rst_n is low and for the first edge after it is released, so a new
// macropixel can be taken on every clock.
// Output: out_valid marks out_data for exactly one cycle; the receiver has
// no way to stall, so it must take each transaction as it appears.
// Pipeline: a transaction taken at an edge passes the input register, the chroma
// product register and the result register before it shows on out_data.
// Throughput: one macropixel per clock while busy is low.
// Configuration: cfg_we with cfg_wdata writes output_mode (0 convert,
// 1 unpack); write it only with no transaction in flight.
// Reset (synchronous, rst_n low): clears the mode to convert and all valid
// flags; transactions in flight are dropped.
module yuyv_to_rgb_converter_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  y2r_pkg::in_t  in_data,
  input  logic          cfg_we,
  input  logic          cfg_wdata,
  output logic          out_valid,
  output y2r_pkg::out_t out_data
);

  logic           busy_r;
  logic           mode_r;
  logic           in_valid_r;
  y2r_pkg::in_t   in_r;
  logic           prod_valid_r;
  y2r_pkg::in_t   raw_r;
  y2r_pkg::prod_t prod_r;
  y2r_pkg::prod_t prod_nxt;
  logic           out_valid_r;
  y2r_pkg::out_t  out_r;
  y2r_pkg::out_t  out_nxt;
  logic [7:0]     l_a, l_b, l_c, r_a, r_b, r_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b1;
      mode_r       <= y2r_pkg::MODE_CONVERT;
      in_valid_r   <= 1'b0;
      prod_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      busy_r       <= 1'b0;
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
      in_valid_r   <= start && !busy_r;
      prod_valid_r <= in_valid_r;
      out_valid_r  <= prod_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    in_r   <= in_data;
    raw_r  <= in_r;
    prod_r <= prod_nxt;
    out_r  <= out_nxt;
  end

  y2r_chroma_mul u_mul (
    .blue_chroma (in_r.blue_chroma),
    .red_chroma  (in_r.red_chroma),
    .prod        (prod_nxt)
  );

  y2r_pixel_clamp u_left (
    .luma   (raw_r.first_luma),
    .prod   (prod_r),
    .chan_a (l_a),
    .chan_b (l_b),
    .chan_c (l_c)
  );

  y2r_pixel_clamp u_right (
    .luma   (raw_r.second_luma),
    .prod   (prod_r),
    .chan_a (r_a),
    .chan_b (r_b),
    .chan_c (r_c)
  );

  always_comb begin
    unique case (mode_r)
      y2r_pkg::MODE_UNPACK: begin
        out_nxt.left_chan_a  = raw_r.first_luma;
        out_nxt.left_chan_b  = raw_r.blue_chroma;
        out_nxt.left_chan_c  = raw_r.red_chroma;
        out_nxt.right_chan_a = raw_r.second_luma;
        out_nxt.right_chan_b = raw_r.blue_chroma;
        out_nxt.right_chan_c = raw_r.red_chroma;
      end
      default: begin
        out_nxt.left_chan_a  = l_a;
        out_nxt.left_chan_b  = l_b;
        out_nxt.left_chan_c  = l_c;
        out_nxt.right_chan_a = r_a;
        out_nxt.right_chan_b = r_b;
        out_nxt.right_chan_c = r_c;
      end
    endcase
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ hdl/y2r_chroma_mul.sv @@
module y2r_chroma_mul (
  input  logic [7:0]     blue_chroma,
  input  logic [7:0]     red_chroma,
  output y2r_pkg::prod_t prod
);

  logic signed [7:0]                  cb;
  logic signed [7:0]                  cr;
  logic signed [y2r_pkg::PROD_W-1:0]  cb_x;
  logic signed [y2r_pkg::PROD_W-1:0]  cr_x;

  // remove chroma offset: flipping the top bit gives value - 128 as signed
  assign cb   = signed'(blue_chroma ^ 8'h80);
  assign cr   = signed'(red_chroma ^ 8'h80);
  assign cb_x = y2r_pkg::PROD_W'(cb);
  assign cr_x = y2r_pkg::PROD_W'(cr);

  assign prod.blue_term  = cb_x * y2r_pkg::K_BLUE_U;
  assign prod.green_term = cb_x * y2r_pkg::K_GREEN_U + cr_x * y2r_pkg::K_GREEN_V;
  assign prod.red_term   = cr_x * y2r_pkg::K_RED_V;

endmodule

@@ hdl/y2r_pixel_clamp.sv @@
module y2r_pixel_clamp (
  input  logic [7:0]     luma,
  input  y2r_pkg::prod_t prod,
  output logic [7:0]     chan_a,
  output logic [7:0]     chan_b,
  output logic [7:0]     chan_c
);

  logic signed [y2r_pkg::ACC_W-1:0] base;
  logic signed [y2r_pkg::ACC_W-1:0] acc_blue;
  logic signed [y2r_pkg::ACC_W-1:0] acc_green;
  logic signed [y2r_pkg::ACC_W-1:0] acc_red;

  function automatic logic [7:0] clamp_chan(input logic signed [y2r_pkg::ACC_W-1:0] acc);
    logic [7:0] res;
    if (acc[y2r_pkg::ACC_W-1]) begin
      res = 8'd0;
    end else if (|acc[y2r_pkg::ACC_W-2:y2r_pkg::FRAC_BITS+8]) begin
      res = 8'hFF;
    end else begin
      res = acc[y2r_pkg::FRAC_BITS+7:y2r_pkg::FRAC_BITS];
    end
    return res;
  endfunction

  assign base      = signed'({{(y2r_pkg::ACC_W-y2r_pkg::FRAC_BITS-8){1'b0}}, luma,
                              {y2r_pkg::FRAC_BITS{1'b0}}});
  assign acc_blue  = base + y2r_pkg::ACC_W'(prod.blue_term);
  assign acc_green = base - y2r_pkg::ACC_W'(prod.green_term);
  assign acc_red   = base + y2r_pkg::ACC_W'(prod.red_term);

  assign chan_a = clamp_chan(acc_blue);
  assign chan_b = clamp_chan(acc_green);
  assign chan_c = clamp_chan(acc_red);

endmodule

@@ hdl/y2r_checker.sv @@
`include "yuyv_to_rgb_converter_unit_macros.svh"

module y2r_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input logic          cfg_we,
  input logic          cfg_wdata,
  input logic          out_valid,
  input y2r_pkg::out_t out_data
);

  logic in_take;
  logic mode_r;
  logic unpack_seen;
  logic chroma_shared;

  assign in_take       = start && !busy;
  assign unpack_seen   = out_valid && (mode_r == y2r_pkg::MODE_UNPACK);
  assign chroma_shared = (out_data.left_chan_b == out_data.right_chan_b) &&
                         (out_data.left_chan_c == out_data.right_chan_c);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= y2r_pkg::MODE_CONVERT;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
    end
  end

  `Y2R_ASSERT_DELAY(a_take_gives_result, clk, rst_n, in_take, 3, out_valid)
  `Y2R_ASSERT_IMPLY(a_result_had_take, clk, rst_n, out_valid, $past(in_take, 3))
  `Y2R_ASSERT_NEXT(a_ready_after_reset, clk, rst_n, !busy, !busy)
  `Y2R_ASSERT_IMPLY(a_unpack_shares_chroma, clk, rst_n, unpack_seen, chroma_shared)

endmodule

bind yuyv_to_rgb_converter_unit y2r_checker u_y2r_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .cfg_we    (cfg_we),
  .cfg_wdata (cfg_wdata),
  .out_valid (out_valid),
  .out_data  (out_data)
);

@@ dv/testbench.sv @@
module testbench;

  localparam int COEF_CR_RED   = 91881;
  localparam int COEF_CB_GREEN = 22544;
  localparam int COEF_CR_GREEN = 46793;
  localparam int COEF_CB_BLUE  = 116130;
  localparam int CHROMA_BIAS   = 128;
  localparam int SCALE_SHIFT   = 16;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  y2r_pkg::in_t in_data = '0;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  logic out_valid;
  y2r_pkg::out_t out_data;

  y2r_pkg::in_t macropixels_to_send[$];
  y2r_pkg::out_t pixel_pairs_due[$];
  logic output_mode_now = y2r_pkg::MODE_CONVERT;
  int idle_pct = 0;
  int burst_left = 0;
  int mismatch_count = 0;
  string chan_names[6] = '{"left_chan_a", "left_chan_b", "left_chan_c",
                           "right_chan_a", "right_chan_b", "right_chan_c"};

  yuyv_to_rgb_converter_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  always #1 clk = ~clk;

  function automatic logic [7:0] clamp_channel(int acc);
    int whole;
    if (acc < 0) begin
      return 8'd0;
    end
    whole = acc >>> SCALE_SHIFT;
    if (whole > 255) begin
      return 8'd255;
    end
    return whole[7:0];
  endfunction

  function automatic logic [23:0] luma_to_bgr(logic [7:0] luma, int cb, int cr);
    int base;
    base = int'(luma) * (1 << SCALE_SHIFT);
    return {clamp_channel(base + COEF_CB_BLUE * cb),
            clamp_channel(base - COEF_CB_GREEN * cb - COEF_CR_GREEN * cr),
            clamp_channel(base + COEF_CR_RED * cr)};
  endfunction

  function automatic y2r_pkg::out_t convert_macropixel(y2r_pkg::in_t px, logic mode);
    int cb;
    int cr;
    cb = int'(px.blue_chroma) - CHROMA_BIAS;
    cr = int'(px.red_chroma) - CHROMA_BIAS;
    if (mode == y2r_pkg::MODE_UNPACK) begin
      return {px.first_luma, px.blue_chroma, px.red_chroma,
              px.second_luma, px.blue_chroma, px.red_chroma};
    end
    return {luma_to_bgr(px.first_luma, cb, cr), luma_to_bgr(px.second_luma, cb, cr)};
  endfunction

  function automatic logic [7:0] random_byte();
    int pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) begin
      return 8'd0;
    end
    if (pick == 1) begin
      return 8'd255;
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // Drive one transaction per accepted slot; record its prediction on acceptance.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (start) begin
        pixel_pairs_due.push_back(convert_macropixel(in_data, output_mode_now));
      end
      if (macropixels_to_send.size() != 0 &&
          (burst_left > 0 || $urandom_range(0, 99) >= idle_pct)) begin
        if (burst_left > 0) begin
          burst_left--;
        end else if ($urandom_range(0, 19) == 0) begin
          burst_left = $urandom_range(8, 40);
        end
        start <= 1'b1;
        in_data <= macropixels_to_send.pop_front();
      end else begin
        start <= 1'b0;
        in_data <= $urandom;
      end
    end
  end

  always @(posedge clk) begin
    y2r_pkg::out_t want;
    logic [47:0] got_bits;
    logic [47:0] want_bits;
    if (rst_n && out_valid) begin
      if (pixel_pairs_due.size() == 0) begin
        $error("out_data transaction with no prediction waiting: %h", out_data);
        mismatch_count++;
      end else begin
        want = pixel_pairs_due.pop_front();
        want_bits = want;
        got_bits = out_data;
        for (int i = 0; i < 6; i++) begin
          if (got_bits[47 - 8 * i -: 8] !== want_bits[47 - 8 * i -: 8]) begin
            $error("%s: expected %0d, got %0d", chan_names[i],
                   want_bits[47 - 8 * i -: 8], got_bits[47 - 8 * i -: 8]);
            mismatch_count++;
          end
        end
      end
    end
  end

  task automatic write_mode(logic mode);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= mode;
    output_mode_now = mode;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_wdata <= 1'($urandom_range(0, 1));
  endtask

  task automatic wait_drained();
    while (macropixels_to_send.size() != 0 || start || pixel_pairs_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (y2r_pkg::LATENCY + 3) @(posedge clk);
  endtask

  task automatic load_directed();
    macropixels_to_send.push_back('{8'd0, 8'd0, 8'd0, 8'd0});
    macropixels_to_send.push_back('{8'd255, 8'd255, 8'd255, 8'd255});
    macropixels_to_send.push_back('{8'd0, 8'd128, 8'd255, 8'd128});
    macropixels_to_send.push_back('{8'd128, 8'd128, 8'd128, 8'd128});
    macropixels_to_send.push_back('{8'd255, 8'd0, 8'd0, 8'd255});
    macropixels_to_send.push_back('{8'd0, 8'd255, 8'd255, 8'd0});
    macropixels_to_send.push_back('{8'd0, 8'd255, 8'd0, 8'd255});
    macropixels_to_send.push_back('{8'd255, 8'd0, 8'd255, 8'd0});
    macropixels_to_send.push_back('{8'd16, 8'd240, 8'd235, 8'd16});
    macropixels_to_send.push_back('{8'd1, 8'd127, 8'd254, 8'd129});
    macropixels_to_send.push_back('{8'd170, 8'd85, 8'd85, 8'd170});
    macropixels_to_send.push_back('{8'd200, 8'd60, 8'd30, 8'd220});
  endtask

  initial begin
    int pct_of_phase[4];
    y2r_pkg::in_t px;
    pct_of_phase = '{0, 71, 0, 20};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    write_mode(y2r_pkg::MODE_CONVERT);
    load_directed();
    wait_drained();
    write_mode(y2r_pkg::MODE_UNPACK);
    load_directed();
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      logic [2:0] pbits;
      pbits = 3'(p);
      write_mode((pbits[1] ^ pbits[2]) ? y2r_pkg::MODE_UNPACK : y2r_pkg::MODE_CONVERT);
      idle_pct = pct_of_phase[p % 4];
      for (int n = 0; n < 200; n++) begin
        px.first_luma = random_byte();
        px.blue_chroma = random_byte();
        px.second_luma = random_byte();
        px.red_chroma = random_byte();
        macropixels_to_send.push_back(px);
      end
      wait_drained();
    end

    if (mismatch_count == 0) begin
      $display("[yuyv_to_rgb_converter_unit] OK");
    end else begin
      $display("[yuyv_to_rgb_converter_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("[yuyv_to_rgb_converter_unit] ERROR");
    $finish;
  end

endmodule
